FILE: hw/rtl/pgdd_pkg.sv
// Package for the packet group delay delta block.
// Holds result status codes, register indexes and fixed burst/clock limits.
// No dependencies.
`timescale 1ns / 1ps

package pgdd_pkg;

  typedef enum logic [2:0] {
    ST_ABSORBED        = 3'd0,
    ST_SAMPLE          = 3'd1,
    ST_REORDERED_PKT   = 3'd2,
    ST_REORDERED_GROUP = 3'd3,
    ST_REORDER_RESET   = 3'd4,
    ST_CLOCK_RESET     = 3'd5
  } status_e;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_TO_US   = 8'd1;

  localparam logic [31:0] GROUP_LENGTH_RESET = 32'd450;
  localparam logic [31:0] TICK_TO_US_RESET   = 32'd186413511;

  localparam logic [31:0] BURST_GAP_US  = 32'd5000;
  localparam logic [31:0] BURST_SPAN_US = 32'd100000;
  localparam logic [31:0] CLOCK_JUMP_US = 32'd3000000;
  localparam logic [64:0] ROUND_HALF    = 65'd8388608;

endpackage

FILE: hw/rtl/pgdd_core.sv
// Group state and per-item decision logic: grouping, burst test, deltas.
// Depends on pgdd_pkg.
`timescale 1ns / 1ps

module pgdd_core #(
  parameter int unsigned TIME_BITS     = 48,
  parameter int unsigned REORDER_LIMIT = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [31:0]            group_len_i,
  input  logic [31:0]            tick_coeff_i,
  input  logic [31:0]            send_stamp_i,
  input  logic [TIME_BITS-1:0]   arrival_us_i,
  input  logic [TIME_BITS-1:0]   local_us_i,
  input  logic [15:0]            packet_bytes_i,
  output pgdd_pkg::status_e      status_o,
  output logic [31:0]            stamp_delta_o,
  output logic [TIME_BITS:0]     arrival_delta_o,
  output logic [32:0]            size_delta_o
);
  import pgdd_pkg::*;

  localparam int unsigned T  = TIME_BITS;
  localparam int unsigned RW = $clog2(REORDER_LIMIT + 1);
  localparam int unsigned CW = (T + 2 > 42) ? T + 2 : 42;

  logic          cur_used_q, cur_used_d;
  logic [31:0]   cur_first_q, cur_first_d;
  logic [31:0]   cur_latest_q, cur_latest_d;
  logic [T-1:0]  cur_first_arr_q, cur_first_arr_d;
  logic [T-1:0]  cur_complete_q, cur_complete_d;
  logic [T-1:0]  cur_local_q, cur_local_d;
  logic [31:0]   cur_bytes_q, cur_bytes_d;
  logic          prev_used_q, prev_used_d;
  logic [31:0]   prev_latest_q, prev_latest_d;
  logic [T-1:0]  prev_complete_q, prev_complete_d;
  logic [T-1:0]  prev_local_q, prev_local_d;
  logic [31:0]   prev_bytes_q, prev_bytes_d;
  logic [RW-1:0] run_q, run_d;

  logic [31:0]        gap_first, gap_latest;
  logic               later_first, older, later_latest;
  logic [63:0]        prod;
  logic [64:0]        prod_rnd;
  logic [40:0]        send_us;
  logic signed [T:0]  arr_delta, span;
  logic signed [CW-1:0] arr_ext, send_ext;
  logic               in_burst, close;
  logic [T:0]         lhs, rhs, jump_diff;
  logic               jump, reordered;
  logic [RW-1:0]      run_inc;
  logic               take, restart, clear;
  logic [31:0]        bytes_base;
  logic [32:0]        bytes_sum;

  assign gap_first    = send_stamp_i - cur_first_q;
  assign gap_latest   = send_stamp_i - cur_latest_q;
  assign later_first  = ((gap_first != 32'd0) && !gap_first[31]) ||
                        ((gap_first == 32'h8000_0000) && (send_stamp_i < cur_first_q));
  assign older        = (gap_first != 32'd0) && !later_first;
  assign later_latest = ((gap_latest != 32'd0) && !gap_latest[31]) ||
                        ((gap_latest == 32'h8000_0000) && (send_stamp_i < cur_latest_q));

  assign prod     = 64'(tick_coeff_i) * 64'(gap_latest);
  assign prod_rnd = {1'b0, prod} + ROUND_HALF;
  assign send_us  = prod_rnd[64:24];

  assign arr_delta = $signed({1'b0, arrival_us_i}) - $signed({1'b0, cur_complete_q});
  assign span      = $signed({1'b0, arrival_us_i}) - $signed({1'b0, cur_first_arr_q});
  assign arr_ext   = $signed({{(CW-T-1){arr_delta[T]}}, arr_delta});
  assign send_ext  = $signed({{(CW-41){1'b0}}, send_us});

  assign in_burst = (send_us == 41'd0) ||
                    ((arr_ext < send_ext) &&
                     (arr_delta <= $signed((T+1)'(BURST_GAP_US))) &&
                     (span < $signed((T+1)'(BURST_SPAN_US))));
  assign close    = !in_burst && (gap_first > group_len_i);

  assign lhs       = {1'b0, cur_complete_q} + {1'b0, prev_local_q};
  assign rhs       = {1'b0, prev_complete_q} + {1'b0, cur_local_q};
  assign jump_diff = lhs - rhs;
  assign jump      = (lhs >= rhs) && (jump_diff >= (T+1)'(CLOCK_JUMP_US));
  assign reordered = cur_complete_q < prev_complete_q;
  assign run_inc   = run_q + RW'(1);

  always_comb begin
    cur_used_d      = cur_used_q;
    cur_first_d     = cur_first_q;
    cur_latest_d    = cur_latest_q;
    cur_first_arr_d = cur_first_arr_q;
    cur_complete_d  = cur_complete_q;
    cur_local_d     = cur_local_q;
    cur_bytes_d     = cur_bytes_q;
    prev_used_d     = prev_used_q;
    prev_latest_d   = prev_latest_q;
    prev_complete_d = prev_complete_q;
    prev_local_d    = prev_local_q;
    prev_bytes_d    = prev_bytes_q;
    run_d           = run_q;
    status_o        = ST_ABSORBED;
    stamp_delta_o   = '0;
    arrival_delta_o = '0;
    size_delta_o    = '0;
    take            = 1'b0;
    restart         = 1'b0;
    clear           = 1'b0;

    if (!cur_used_q) begin
      cur_first_d     = send_stamp_i;
      cur_latest_d    = send_stamp_i;
      cur_first_arr_d = arrival_us_i;
      take            = 1'b1;
    end else if (older) begin
      status_o = ST_REORDERED_PKT;
    end else if (close) begin
      if (prev_used_q && jump) begin
        clear    = 1'b1;
        status_o = ST_CLOCK_RESET;
      end else if (prev_used_q && reordered) begin
        if (run_inc >= RW'(REORDER_LIMIT)) begin
          clear    = 1'b1;
          status_o = ST_REORDER_RESET;
        end else begin
          run_d    = run_inc;
          status_o = ST_REORDERED_GROUP;
        end
      end else begin
        if (prev_used_q) begin
          run_d           = '0;
          status_o        = ST_SAMPLE;
          stamp_delta_o   = cur_latest_q - prev_latest_q;
          arrival_delta_o = {1'b0, cur_complete_q} - {1'b0, prev_complete_q};
          size_delta_o    = {1'b0, cur_bytes_q} - {1'b0, prev_bytes_q};
        end
        prev_used_d     = 1'b1;
        prev_latest_d   = cur_latest_q;
        prev_complete_d = cur_complete_q;
        prev_local_d    = cur_local_q;
        prev_bytes_d    = cur_bytes_q;
        cur_first_d     = send_stamp_i;
        cur_latest_d    = send_stamp_i;
        cur_first_arr_d = arrival_us_i;
        restart         = 1'b1;
        take            = 1'b1;
      end
    end else begin
      if (later_latest) begin
        cur_latest_d = send_stamp_i;
      end
      take = 1'b1;
    end

    bytes_base = restart ? 32'd0 : cur_bytes_q;
    bytes_sum  = {1'b0, bytes_base} + 33'(packet_bytes_i);

    if (take) begin
      cur_bytes_d    = bytes_sum[32] ? 32'hFFFF_FFFF : bytes_sum[31:0];
      cur_complete_d = arrival_us_i;
      cur_local_d    = local_us_i;
      cur_used_d     = 1'b1;
    end

    if (clear) begin
      cur_used_d      = 1'b0;
      cur_first_d     = '0;
      cur_latest_d    = '0;
      cur_first_arr_d = '0;
      cur_complete_d  = '0;
      cur_local_d     = '0;
      cur_bytes_d     = '0;
      prev_used_d     = 1'b0;
      prev_latest_d   = '0;
      prev_complete_d = '0;
      prev_local_d    = '0;
      prev_bytes_d    = '0;
      run_d           = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_used_q      <= 1'b0;
      cur_first_q     <= '0;
      cur_latest_q    <= '0;
      cur_first_arr_q <= '0;
      cur_complete_q  <= '0;
      cur_local_q     <= '0;
      cur_bytes_q     <= '0;
      prev_used_q     <= 1'b0;
      prev_latest_q   <= '0;
      prev_complete_q <= '0;
      prev_local_q    <= '0;
      prev_bytes_q    <= '0;
      run_q           <= '0;
    end else if (step_i) begin
      cur_used_q      <= cur_used_d;
      cur_first_q     <= cur_first_d;
      cur_latest_q    <= cur_latest_d;
      cur_first_arr_q <= cur_first_arr_d;
      cur_complete_q  <= cur_complete_d;
      cur_local_q     <= cur_local_d;
      cur_bytes_q     <= cur_bytes_d;
      prev_used_q     <= prev_used_d;
      prev_latest_q   <= prev_latest_d;
      prev_complete_q <= prev_complete_d;
      prev_local_q    <= prev_local_d;
      prev_bytes_q    <= prev_bytes_d;
      run_q           <= run_d;
    end
  end

endmodule

FILE: hw/rtl/packet_group_delay_delta.sv
// Top level of the packet group delay delta block: stream ports, config
// registers, input and result registers. Depends on pgdd_pkg and pgdd_core.
`timescale 1ns / 1ps

// One result item per packet item, one item per clock cycle sustained while
// m_axis_tready_i stays high; items and results are held in input and output
// registers. The path that sets the clock is the group-state loop in pgdd_core:
// a 32x32 tick-to-microsecond multiply, the burst compares and the group state
// update, all in one combinational path. After reset group_length_ticks is 450
// and tick_to_us_q8_24 is 186413511; write them only while no item is in flight.
module packet_group_delay_delta #(
  parameter int unsigned TIME_BITS     = 48,
  parameter int unsigned REORDER_LIMIT = 3
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid_i,
  output logic                                          s_axis_tready_o,
  // send_stamp, arrival_us, local_us, packet_bytes
  input  logic [((2*TIME_BITS+48+7)/8)*8-1:0]           s_axis_tdata_i,
  output logic                                          m_axis_tvalid_o,
  input  logic                                          m_axis_tready_i,
  // stamp_delta, arrival_delta_us, size_delta
  output logic [((TIME_BITS+66+7)/8)*8-1:0]             m_axis_tdata_o,
  // status
  output logic [2:0]                                    m_axis_tuser_o,
  input  logic                                          cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  logic [pgdd_pkg::CFG_IDX_W-1:0]                cfg_index_i,
  input  logic [31:0]                                   cfg_data_i
);
  import pgdd_pkg::*;

  localparam int unsigned T     = TIME_BITS;
  localparam int unsigned OUT_W = ((T + 66 + 7) / 8) * 8;

  logic [31:0]  group_len_q, tick_coeff_q;

  logic         in_valid_q;
  logic [31:0]  in_stamp_q;
  logic [T-1:0] in_arrival_q, in_local_q;
  logic [15:0]  in_bytes_q;

  logic         out_valid_q;
  status_e      out_status_q;
  logic [31:0]  out_stamp_q;
  logic [T:0]   out_arrival_q;
  logic [32:0]  out_size_q;

  logic         advance, step;
  status_e      res_status;
  logic [31:0]  res_stamp;
  logic [T:0]   res_arrival;
  logic [32:0]  res_size;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_len_q  <= GROUP_LENGTH_RESET;
      tick_coeff_q <= TICK_TO_US_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GROUP_LENGTH: group_len_q  <= cfg_data_i;
        REG_TICK_TO_US:   tick_coeff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_stamp_q   <= s_axis_tdata_i[31:0];
      in_arrival_q <= s_axis_tdata_i[32 +: T];
      in_local_q   <= s_axis_tdata_i[32+T +: T];
      in_bytes_q   <= s_axis_tdata_i[32+2*T +: 16];
    end
  end

  pgdd_core #(
    .TIME_BITS     (TIME_BITS),
    .REORDER_LIMIT (REORDER_LIMIT)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .group_len_i     (group_len_q),
    .tick_coeff_i    (tick_coeff_q),
    .send_stamp_i    (in_stamp_q),
    .arrival_us_i    (in_arrival_q),
    .local_us_i      (in_local_q),
    .packet_bytes_i  (in_bytes_q),
    .status_o        (res_status),
    .stamp_delta_o   (res_stamp),
    .arrival_delta_o (res_arrival),
    .size_delta_o    (res_size)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_status_q  <= res_status;
      out_stamp_q   <= res_stamp;
      out_arrival_q <= res_arrival;
      out_size_q    <= res_size;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OUT_W'({out_size_q, out_arrival_q, out_stamp_q});

  a_quiet_unless_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ST_SAMPLE)) |-> (m_axis_tdata_o == '0))
    else $error("non-sample result carries nonzero deltas");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid_o)
    else $error("processed item produced no result");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a full pipeline");

endmodule

FILE: test/packet_group_delay_delta_test.sv
// Self-checking testbench for packet_group_delay_delta: directed rows, then random
// packet traffic under several register settings, checked against an in-bench model.
// Depends on pgdd_pkg and the packet_group_delay_delta RTL.
`timescale 1ns / 1ps

module packet_group_delay_delta_test;
  import pgdd_pkg::*;

  localparam int unsigned TIME_W       = 48;
  localparam int unsigned REORDER_MAX  = 3;
  localparam int unsigned IN_W         = ((2*TIME_W+48+7)/8)*8;
  localparam int unsigned OUT_W        = ((TIME_W+66+7)/8)*8;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned HOLD_CNT     = 16;
  localparam int unsigned DRAIN_CYCLES = 4;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LOW = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_TOP = 8'hFF;

  typedef struct packed {
    bit [31:0]       stamp;
    bit [TIME_W-1:0] arrival;
    bit [TIME_W-1:0] local_us;
    bit [15:0]       bytes;
  } packet_t;

  typedef struct packed {
    status_e   status;
    bit [31:0] stamp_delta;
    bit [48:0] arrival_delta;
    bit [32:0] size_delta;
  } delta_result_t;

  typedef struct packed {
    bit              cur_used;
    bit [31:0]       cur_first_stamp;
    bit [31:0]       cur_latest_stamp;
    bit [TIME_W-1:0] cur_first_arrival;
    bit [TIME_W-1:0] cur_complete_arrival;
    bit [TIME_W-1:0] cur_last_local;
    bit [31:0]       cur_bytes;
    bit              prev_used;
    bit [31:0]       prev_latest_stamp;
    bit [TIME_W-1:0] prev_complete_arrival;
    bit [TIME_W-1:0] prev_last_local;
    bit [31:0]       prev_bytes;
    bit [3:0]        reorder_run;
  } group_state_t;

  typedef struct packed {
    packet_t       pkt;
    bit            typed;
    delta_result_t res;
  } directed_row_t;

  localparam delta_result_t NO_EXP            = '{ST_ABSORBED, 32'd0, 49'd0, 33'd0};
  localparam delta_result_t EXP_ABSORBED      = '{ST_ABSORBED, 32'd0, 49'd0, 33'd0};
  localparam delta_result_t EXP_STALE         = '{ST_REORDERED_PKT, 32'd0, 49'd0, 33'd0};
  localparam delta_result_t EXP_GROUP_REORDER = '{ST_REORDERED_GROUP, 32'd0, 49'd0, 33'd0};
  localparam delta_result_t EXP_REORDER_RESET = '{ST_REORDER_RESET, 32'd0, 49'd0, 33'd0};
  localparam delta_result_t EXP_CLOCK_RESET   = '{ST_CLOCK_RESET, 32'd0, 49'd0, 33'd0};

  localparam int DIRECTED_ROWS = 20;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{32'd0, 48'd1000000, 48'd1000000, 16'd0}, 1'b1, EXP_ABSORBED},
    '{'{32'hFFFF_FFFF, 48'd1000100, 48'd1000100, 16'd1}, 1'b1, EXP_STALE},
    '{'{32'h8000_0000, 48'd1000100, 48'd1000100, 16'd1}, 1'b1, EXP_STALE},
    '{'{32'h7FFF_FFFF, 48'd1000200, 48'd1000200, 16'hFFFF}, 1'b0, NO_EXP},
    '{'{32'd100, 48'd1010000, 48'd1010000, 16'd1000}, 1'b0, NO_EXP},
    '{'{32'd1000, 48'd1030000, 48'd1030000, 16'd0}, 1'b1, EXP_ABSORBED},
    '{'{32'd1100, 48'd1031000, 48'd1031000, 16'd500}, 1'b0, NO_EXP},
    '{'{32'd3000, 48'd1060000, 48'd1060000, 16'd1}, 1'b0, NO_EXP},
    '{'{32'd3100, 48'd5000000, 48'd1061000, 16'd10}, 1'b0, NO_EXP},
    '{'{32'd5000, 48'd5100000, 48'd1100000, 16'd10}, 1'b1, EXP_CLOCK_RESET},
    '{'{32'd10000, 48'd2000000, 48'd2000000, 16'd0}, 1'b1, EXP_ABSORBED},
    '{'{32'd10100, 48'd2200000, 48'd2200000, 16'd0}, 1'b0, NO_EXP},
    '{'{32'd11000, 48'd2150000, 48'd2150000, 16'd0}, 1'b0, NO_EXP},
    '{'{32'd12000, 48'd2400000, 48'd2400000, 16'd0}, 1'b1, EXP_GROUP_REORDER},
    '{'{32'd12000, 48'd2400000, 48'd2400000, 16'd0}, 1'b1, EXP_GROUP_REORDER},
    '{'{32'd12000, 48'd2400000, 48'd2400000, 16'd0}, 1'b1, EXP_REORDER_RESET},
    '{'{32'hFFFF_FFF0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF}, 1'b1, EXP_ABSORBED},
    '{'{32'h0000_0100, 48'd0, 48'd0, 16'd0}, 1'b0, NO_EXP},
    '{'{32'h0000_1000, 48'd50000, 48'd50000, 16'd0}, 1'b0, NO_EXP},
    '{'{32'h0000_2000, 48'd100000, 48'd100000, 16'hFFFF}, 1'b0, NO_EXP}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [OUT_W-1:0]     m_axis_tdata_o;
  logic [2:0]           m_axis_tuser_o;
  logic                 cfg_ready_o;

  group_state_t    grp = '0;
  bit [31:0]       cfg_group_length = GROUP_LENGTH_RESET;
  bit [31:0]       cfg_tick_coeff = TICK_TO_US_RESET;
  delta_result_t   pending_deltas[$];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;
  int              burst_left = 0;
  int              rx_left = 0;
  bit [31:0]       tx_stamp;
  bit [TIME_W-1:0] tx_arr;
  bit [TIME_W-1:0] tx_loc;

  packet_group_delay_delta #(
    .TIME_BITS    (TIME_W),
    .REORDER_LIMIT(REORDER_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit stamp_newer(bit [31:0] a, bit [31:0] b);
    return (a > b && (a - b) <= 32'h7FFF_FFFF) || (b > a && (b - a) > 32'h7FFF_FFFF);
  endfunction

  function automatic bit within_burst(packet_t p);
    bit [31:0] gap;
    bit [63:0] prod;
    longint    send_us;
    longint    arr_delta;
    longint    span;
    gap = p.stamp - grp.cur_latest_stamp;
    prod = 64'(cfg_tick_coeff) * 64'(gap);
    send_us = longint'((prod + 64'(ROUND_HALF)) >> 24);
    arr_delta = longint'({16'd0, p.arrival}) - longint'({16'd0, grp.cur_complete_arrival});
    span = longint'({16'd0, p.arrival}) - longint'({16'd0, grp.cur_first_arrival});
    if (send_us == 0) return 1'b1;
    return arr_delta < send_us && arr_delta <= longint'(BURST_GAP_US) &&
           span < longint'(BURST_SPAN_US);
  endfunction

  function automatic delta_result_t advance_groups(packet_t p);
    delta_result_t r;
    bit [63:0]     lhs;
    bit [63:0]     rhs;
    bit [32:0]     byte_sum;
    r = NO_EXP;
    if (!grp.cur_used) begin
      grp.cur_first_stamp = p.stamp;
      grp.cur_latest_stamp = p.stamp;
      grp.cur_first_arrival = p.arrival;
    end else if (p.stamp != grp.cur_first_stamp && !stamp_newer(p.stamp, grp.cur_first_stamp)) begin
      r.status = ST_REORDERED_PKT;
      return r;
    end else if (!within_burst(p) && (p.stamp - grp.cur_first_stamp) > cfg_group_length) begin
      if (grp.prev_used) begin
        lhs = 64'(grp.cur_complete_arrival) + 64'(grp.prev_last_local);
        rhs = 64'(grp.prev_complete_arrival) + 64'(grp.cur_last_local);
        if (lhs >= rhs && lhs - rhs >= 64'(CLOCK_JUMP_US)) begin
          grp = '0;
          r.status = ST_CLOCK_RESET;
          return r;
        end
        if (grp.cur_complete_arrival < grp.prev_complete_arrival) begin
          grp.reorder_run = grp.reorder_run + 4'd1;
          if (grp.reorder_run >= REORDER_MAX) begin
            grp = '0;
            r.status = ST_REORDER_RESET;
          end else begin
            r.status = ST_REORDERED_GROUP;
          end
          return r;
        end
        grp.reorder_run = '0;
        r.status = ST_SAMPLE;
        r.stamp_delta = grp.cur_latest_stamp - grp.prev_latest_stamp;
        r.arrival_delta = {1'b0, grp.cur_complete_arrival} - {1'b0, grp.prev_complete_arrival};
        r.size_delta = {1'b0, grp.cur_bytes} - {1'b0, grp.prev_bytes};
      end
      grp.prev_used = 1'b1;
      grp.prev_latest_stamp = grp.cur_latest_stamp;
      grp.prev_complete_arrival = grp.cur_complete_arrival;
      grp.prev_last_local = grp.cur_last_local;
      grp.prev_bytes = grp.cur_bytes;
      grp.cur_first_stamp = p.stamp;
      grp.cur_latest_stamp = p.stamp;
      grp.cur_first_arrival = p.arrival;
      grp.cur_bytes = 32'd0;
    end else if (stamp_newer(p.stamp, grp.cur_latest_stamp)) begin
      grp.cur_latest_stamp = p.stamp;
    end
    byte_sum = {1'b0, grp.cur_bytes} + 33'(p.bytes);
    grp.cur_bytes = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
    grp.cur_complete_arrival = p.arrival;
    grp.cur_last_local = p.local_us;
    grp.cur_used = 1'b1;
    return r;
  endfunction

  task automatic send_packet(input packet_t p, input bit typed, input delta_result_t typed_res);
    int            gap;
    delta_result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {p.bytes, p.local_us, p.arrival, p.stamp};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    burst_left--;
    predicted = advance_groups(p);
    pending_deltas.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_deltas.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == REG_GROUP_LENGTH) cfg_group_length = value;
    else if (idx == REG_TICK_TO_US) cfg_tick_coeff = value;
    @(posedge clk_i);
  endtask

  task automatic run_traffic(input int n_items);
    int              sent;
    int              kind;
    int              npk;
    bit [TIME_W-1:0] adv;
    packet_t         p;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        p.stamp = $urandom();
        p.arrival = 48'({$urandom(), $urandom()});
        p.local_us = 48'({$urandom(), $urandom()});
        p.bytes = 16'($urandom());
        send_packet(p, 1'b0, NO_EXP);
        sent++;
      end else begin
        tx_stamp += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 1500);
        adv = 48'($urandom_range(0, 40000));
        if (kind < 12) begin
          adv = 48'($urandom_range(50000, 300000));
          tx_arr -= adv;
          tx_loc -= adv;
        end else if (kind < 15) begin
          tx_arr += 48'd3000000 + 48'($urandom_range(0, 2000000));
          tx_loc += adv;
        end else begin
          tx_arr += adv;
          tx_loc += adv + 48'($urandom_range(0, 50));
        end
        npk = $urandom_range(1, 6);
        repeat (npk) begin
          if ($urandom_range(0, 19) == 0) begin
            p.stamp = tx_stamp - $urandom_range(500, 100000);
          end else begin
            tx_stamp += $urandom_range(0, 3);
            adv = ($urandom_range(0, 5) == 0) ? 48'($urandom_range(5000, 150000))
                                              : 48'($urandom_range(0, 2000));
            tx_arr += adv;
            tx_loc += adv;
            p.stamp = tx_stamp;
          end
          p.arrival = tx_arr;
          p.local_us = tx_loc;
          case ($urandom_range(0, 9))
            0: p.bytes = 16'd0;
            1: p.bytes = 16'hFFFF;
            default: p.bytes = 16'($urandom_range(50, 1500));
          endcase
          send_packet(p, 1'b0, NO_EXP);
          sent++;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      case ($urandom_range(0, 9))
        0: begin
          m_tready <= 1'b1;
          rx_left <= $urandom_range(100, 300);
        end
        1, 2, 3: begin
          m_tready <= 1'b0;
          rx_left <= $urandom_range(1, 6);
        end
        default: begin
          m_tready <= 1'b1;
          rx_left <= $urandom_range(1, 20);
        end
      endcase
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  always @(posedge clk_i) begin
    delta_result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (pending_deltas.size() == 0) begin
        mismatch_count++;
        $error("result item with no expectation pending: status 0x%0h", m_axis_tuser_o);
      end else begin
        exp_r = pending_deltas.pop_front();
        check_field("status", 64'(exp_r.status), 64'(m_axis_tuser_o));
        check_field("stamp_delta", 64'(exp_r.stamp_delta), 64'(m_axis_tdata_o[31:0]));
        check_field("arrival_delta_us", 64'(exp_r.arrival_delta), 64'(m_axis_tdata_o[80:32]));
        check_field("size_delta", 64'(exp_r.size_delta), 64'(m_axis_tdata_o[113:81]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("packet_group_delay_delta verification failed");
      $finish;
    end
  end

  initial begin
    packet_t fp;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_packet(DIRECTED[i].pkt, DIRECTED[i].typed, DIRECTED[i].res);
    drain_results();

    tx_stamp = ($urandom_range(0, 1) == 0) ? 32'hFFFF_0000 : $urandom();
    tx_arr = ($urandom_range(0, 1) == 0) ? 48'hFFFF_FFF0_0000 : 48'({$urandom(), $urandom()});
    tx_loc = tx_arr;
    run_traffic(150);
    drain_results();

    cfg_write(REG_GROUP_LENGTH, 32'd0);
    cfg_write(REG_TICK_TO_US, 32'h0100_0000);
    run_traffic(100);
    drain_results();

    cfg_write(REG_GROUP_LENGTH, 32'hFFFF_FFFF);
    cfg_write(REG_TICK_TO_US, 32'hFFFF_FFFF);
    run_traffic(60);
    drain_results();

    cfg_write(REG_GROUP_LENGTH, 32'd90);
    cfg_write(REG_TICK_TO_US, 32'd0);
    run_traffic(40);
    drain_results();

    cfg_write(REG_UNMAPPED_LOW, $urandom());
    cfg_write(REG_UNMAPPED_TOP, $urandom());
    cfg_write(REG_GROUP_LENGTH, 32'd3000);
    cfg_write(REG_TICK_TO_US, TICK_TO_US_RESET);
    run_traffic(150);
    drain_results();

    // hold one group open on full-size packets, then close it and the group that follows
    cfg_write(REG_GROUP_LENGTH, 32'hFFFF_FFFF);
    fp.stamp = grp.cur_used ? grp.cur_first_stamp : tx_stamp;
    fp.arrival = grp.prev_used ? grp.prev_complete_arrival + 48'd10000 : tx_arr;
    fp.local_us = grp.prev_used ? grp.prev_last_local + 48'd10000 : tx_loc;
    fp.bytes = 16'hFFFF;
    repeat (HOLD_CNT) send_packet(fp, 1'b0, NO_EXP);
    drain_results();
    cfg_write(REG_GROUP_LENGTH, 32'd0);
    repeat (2) begin
      fp.stamp += 32'd1000;
      fp.arrival += 48'd1000000;
      fp.local_us += 48'd1000000;
      fp.bytes = 16'd700;
      send_packet(fp, 1'b0, NO_EXP);
    end
    drain_results();

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("packet_group_delay_delta verification clean");
    end else begin
      $display("packet_group_delay_delta verification failed");
    end
    $finish;
  end

endmodule
